// ----- src/four_level_page_table_walker_core_assert.svh -----
// Assertion macros shared by the walker RTL.
`ifndef FOUR_LEVEL_PAGE_TABLE_WALKER_CORE_ASSERT_SVH
`define FOUR_LEVEL_PAGE_TABLE_WALKER_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define PTW_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("walker assertion failed");

// Next-cycle implication, disabled during reset.
`define PTW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("walker assertion failed");

`endif

// ----- src/ptw_pkg.sv -----
`timescale 1ns / 1ps
package ptw_pkg;

  localparam int ADDR_W     = 52;
  localparam int VA_W       = 64;
  localparam int PAGE_SHIFT = 12;
  localparam int INDEX_BITS = 9;
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 64;
  localparam logic [29:0] OFFSET_1G_MASK = 30'h3FFFFFFF;

  typedef enum logic [2:0] {
    WL_IDLE = 3'd0,
    WL_PML4 = 3'd1,
    WL_PDPT = 3'd2,
    WL_PD   = 3'd3,
    WL_PT   = 3'd4
  } walk_level_t;

  typedef enum logic [1:0] {
    PL_NONE = 2'd0,
    PL_1G   = 2'd1,
    PL_2M   = 2'd2,
    PL_4K   = 2'd3
  } page_level_t;

  typedef enum logic {
    MODE_TRANSLATE = 1'b0,
    MODE_RESPONSE  = 1'b1
  } mode_t;

  typedef enum logic {
    KIND_READ = 1'b0,
    KIND_DONE = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    REG_TABLE_ROOT = 2'd0,
    REG_USER_LOW   = 2'd1,
    REG_USER_HIGH  = 2'd2
  } reg_index_t;

  typedef struct packed {
    logic              mode;
    logic [VA_W-1:0]   virtual_address;
    logic              user_check;
    logic [VA_W-1:0]   read_data;
  } ptw_req_t;

  typedef struct packed {
    logic              kind;
    logic [ADDR_W-1:0] read_address;
    logic              found;
    logic [1:0]        page_level;
    logic [ADDR_W-1:0] entry_address;
    logic [ADDR_W-1:0] phys_address;
  } ptw_rsp_t;

  typedef struct packed {
    logic [ADDR_W-1:0] table_root;
    logic [VA_W-1:0]   user_low;
    logic [VA_W-1:0]   user_high;
  } ptw_cfg_t;

  typedef struct packed {
    logic        has_result;
    ptw_rsp_t    rsp;
    walk_level_t level_nxt;
    logic        load_va;
    logic        load_entry;
  } ptw_step_t;

endpackage

// ----- src/ptw_stream_if.sv -----
`timescale 1ns / 1ps
interface ptw_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- src/ptw_cfg.sv -----
`timescale 1ns / 1ps
module ptw_cfg
  import ptw_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output ptw_cfg_t              cfg
);

  ptw_cfg_t   cfg_r;
  ptw_cfg_t   cfg_nxt;
  reg_index_t reg_sel;
  logic       wr_en;

  // registers sit on 8-byte boundaries
  assign reg_sel = reg_index_t'(paddr[4:3]);
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (reg_sel)
        REG_TABLE_ROOT: cfg_nxt.table_root = pwdata[ADDR_W-1:0];
        REG_USER_LOW:   cfg_nxt.user_low   = pwdata;
        REG_USER_HIGH:  cfg_nxt.user_high  = pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_TABLE_ROOT: prdata = {{(CFG_DATA_W-ADDR_W){1'b0}}, cfg_r.table_root};
      REG_USER_LOW:   prdata = cfg_r.user_low;
      REG_USER_HIGH:  prdata = cfg_r.user_high;
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- src/ptw_step.sv -----
`timescale 1ns / 1ps
module ptw_step
  import ptw_pkg::*;
#(
  parameter int PHYS_ADDR_BITS = 52
) (
  input  ptw_req_t          req,
  input  walk_level_t       walk_level,
  input  logic [VA_W-1:0]   held_address,
  input  logic [ADDR_W-1:0] pending_entry,
  input  ptw_cfg_t          cfg,
  output ptw_step_t         step
);

  // entry bits PHYS_ADDR_BITS-1..12 hold the frame
  localparam logic [ADDR_W-1:0] ONES_W     = {ADDR_W{1'b1}};
  localparam logic [ADDR_W-1:0] FRAME_MASK =
    (ONES_W >> (ADDR_W - PHYS_ADDR_BITS)) & ~((ADDR_W)'(2 ** PAGE_SHIFT - 1));

  logic [VA_W-1:0]       va;
  logic [ADDR_W-1:0]     frame;
  logic [ADDR_W-1:0]     root_base;
  logic [INDEX_BITS-1:0] next_index;
  logic [ADDR_W-1:0]     next_read;
  logic [ADDR_W-1:0]     root_read;
  logic [ADDR_W-1:0]     page_offset;
  logic [ADDR_W-1:0]     phys;
  logic                  canonical;
  logic                  in_user;
  logic                  entry_zero;
  logic                  page_size;

  assign va         = req.virtual_address;
  assign frame      = req.read_data[ADDR_W-1:0] & FRAME_MASK;
  assign root_base  = cfg.table_root & ~((ADDR_W)'(2 ** PAGE_SHIFT - 1));
  assign root_read  = root_base | {{(ADDR_W-PAGE_SHIFT){1'b0}}, va[47:39], 3'b000};
  assign canonical  = (va[63:47] == '0) || (va[63:47] == '1);
  assign in_user    = (va >= cfg.user_low) && (va < cfg.user_high);
  assign entry_zero = (req.read_data == '0);
  assign page_size  = req.read_data[7];

  // index into the table read after the current entry
  always_comb begin
    unique case (walk_level)
      WL_PML4: next_index = held_address[38:30];
      WL_PDPT: next_index = held_address[29:21];
      WL_PD:   next_index = held_address[20:12];
      default: next_index = '0;
    endcase
  end

  // frame low bits are clear, so OR in the index
  assign next_read = frame | {{(ADDR_W-PAGE_SHIFT){1'b0}}, next_index, 3'b000};

  always_comb begin
    unique case (walk_level)
      WL_PDPT: page_offset = {{(ADDR_W-30){1'b0}}, held_address[29:0] & OFFSET_1G_MASK};
      WL_PD:   page_offset = {{(ADDR_W-21){1'b0}}, held_address[20:0]};
      default: page_offset = {{(ADDR_W-PAGE_SHIFT){1'b0}}, held_address[PAGE_SHIFT-1:0]};
    endcase
  end

  assign phys = frame + page_offset;

  always_comb begin
    step            = '0;
    step.level_nxt  = walk_level;
    case (req.mode)
      MODE_TRANSLATE: begin
        if (walk_level == WL_IDLE) begin
          step.has_result = 1'b1;
          if (!canonical || (req.user_check && !in_user)) begin
            step.rsp.kind = KIND_DONE;
          end else begin
            step.rsp.kind         = KIND_READ;
            step.rsp.read_address = root_read;
            step.level_nxt        = WL_PML4;
            step.load_va          = 1'b1;
            step.load_entry       = 1'b1;
          end
        end
      end
      default: begin
        unique case (walk_level)
          WL_PML4, WL_PDPT, WL_PD, WL_PT: begin
            step.has_result = 1'b1;
            if (entry_zero) begin
              step.rsp.kind  = KIND_DONE;
              step.level_nxt = WL_IDLE;
            end else if (walk_level == WL_PT ||
                         (page_size && walk_level != WL_PML4)) begin
              step.rsp.kind          = KIND_DONE;
              step.rsp.found         = 1'b1;
              step.rsp.entry_address = pending_entry;
              step.rsp.phys_address  = phys;
              step.level_nxt         = WL_IDLE;
              if (walk_level == WL_PDPT) begin
                step.rsp.page_level = PL_1G;
              end else if (walk_level == WL_PD) begin
                step.rsp.page_level = PL_2M;
              end else begin
                step.rsp.page_level = PL_4K;
              end
            end else begin
              step.rsp.kind         = KIND_READ;
              step.rsp.read_address = next_read;
              step.level_nxt        = walk_level_t'(walk_level + 3'd1);
              step.load_entry       = 1'b1;
            end
          end
          default: begin
            // stray response: drop it
            step.level_nxt = WL_IDLE;
          end
        endcase
      end
    endcase
  end

endmodule

// ----- src/four_level_page_table_walker_core.sv -----
`timescale 1ns / 1ps
// Four-level page table walker. Each transaction on in_ch is either a translate
// request (mode 0) or the word returned for the last table read (mode 1); each
// yields at most one transaction on out_ch: a table read to issue (kind 0) or the
// walk outcome (kind 1). Requests taken while a walk runs and responses taken
// while idle are dropped without a result. An item passes through the input
// register, then the step logic into the result register; a new item is taken
// every cycle while out_ch accepts results, and only a stalled result register
// holds the input side. Configuration lives on a 64-bit APB port at byte addresses
// 0, 8 and 16; the user must write it only while idle, which is not enforced.
`include "four_level_page_table_walker_core_assert.svh"
module four_level_page_table_walker_core
  import ptw_pkg::*;
#(
  parameter int PHYS_ADDR_BITS = 52
) (
  input  logic                  clk,
  input  logic                  rst_n,
  ptw_stream_if.sink            in_ch,
  ptw_stream_if.source          out_ch,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  ptw_cfg_t          cfg;
  ptw_step_t         step;

  ptw_req_t          in_r;
  logic              in_valid_r;
  logic              in_valid_nxt;
  ptw_rsp_t          out_r;
  logic              out_valid_r;
  logic              out_valid_nxt;
  walk_level_t       walk_level_r;
  logic [VA_W-1:0]   held_address_r;
  logic [ADDR_W-1:0] pending_entry_r;

  logic              out_free;
  logic              fire;
  logic              in_take;

  ptw_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  ptw_step #(
    .PHYS_ADDR_BITS (PHYS_ADDR_BITS)
  ) u_step (
    .req           (in_r),
    .walk_level    (walk_level_r),
    .held_address  (held_address_r),
    .pending_entry (pending_entry_r),
    .cfg           (cfg),
    .step          (step)
  );

  assign out_free     = !out_valid_r || out_ch.ready;
  // an item with no result never waits on the output side
  assign fire         = in_valid_r && (out_free || !step.has_result);
  assign in_ch.ready  = !in_valid_r || fire;
  assign in_take      = in_ch.valid && in_ch.ready;

  assign in_valid_nxt  = in_take ? 1'b1 : (fire ? 1'b0 : in_valid_r);
  assign out_valid_nxt = (fire && step.has_result) ? 1'b1 :
                         (out_ch.ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r      <= 1'b0;
      out_valid_r     <= 1'b0;
      walk_level_r    <= WL_IDLE;
      held_address_r  <= '0;
      pending_entry_r <= '0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (fire) begin
        walk_level_r <= step.level_nxt;
        if (step.load_va) begin
          held_address_r <= in_r.virtual_address;
        end
        if (step.load_entry) begin
          pending_entry_r <= step.rsp.read_address;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_r <= in_ch.data;
    end
    if (fire && step.has_result) begin
      out_r <= step.rsp;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_r;

  `PTW_ASSERT_NEXT(a_done_goes_idle, clk, rst_n,
    fire && step.has_result && step.rsp.kind == KIND_DONE, walk_level_r == WL_IDLE)
  `PTW_ASSERT_IMPLY(a_stall_blocks_input, clk, rst_n,
    in_valid_r && step.has_result && !out_free, !in_ch.ready)
  `PTW_ASSERT_IMPLY(a_found_has_level, clk, rst_n,
    out_valid_r && out_r.found, out_r.page_level != PL_NONE && out_r.kind == KIND_DONE)

endmodule
